// ===== rtl/bfi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared constants for the interpreter core: mode codes, opcodes, defaults.
// ----------------------------------------------------------------------------
package bfi_pkg;

    localparam int MEM_DEPTH_DEF   = 65536;
    localparam int PROG_DEPTH_DEF  = 4096;
    localparam int INPUT_DEPTH_DEF = 4096;

    localparam logic [16:0] MEM_SIZE_RST = 17'h10000;

    localparam logic [1:0] MODE_LOAD_PROG  = 2'd0;
    localparam logic [1:0] MODE_LOAD_INPUT = 2'd1;
    localparam logic [1:0] MODE_STEP       = 2'd2;
    localparam logic [1:0] MODE_RESTART    = 2'd3;

    localparam logic [7:0] OP_OPEN  = 8'h5B; // [
    localparam logic [7:0] OP_CLOSE = 8'h5D; // ]
    localparam logic [7:0] OP_INC   = 8'h2B; // +
    localparam logic [7:0] OP_DEC   = 8'h2D; // -
    localparam logic [7:0] OP_LEFT  = 8'h3C; // <
    localparam logic [7:0] OP_RIGHT = 8'h3E; // >
    localparam logic [7:0] OP_READ  = 8'h2C; // ,
    localparam logic [7:0] EOF_BYTE = 8'hFF;

endpackage

// ===== rtl/bfi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/brainfuck_interpreter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core
// Byte-tape interpreter with program store, bracket matching and input queue.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready): mode + value. Mode 0 appends a program
//   byte, 1 appends an input byte, 2 runs one instruction, 3 restarts.
//   out channel (out_valid/out_ready): one item per input item with pc,
//   data pointer, current cell, halted and bracket_error after that item.
//   cfg channel (cfg_valid/cfg_ready): mem_size, always ready.
// Sequencing: loads go to S_DONE (a matched ']' via S_LOAD_RD, S_LOAD_WR,
//   writing both jump entries); steps via S_EXEC (skipped while halted), with
//   '<' and '>' then S_TAPE, waiting on the tape read at the new pointer. Items
//   go one at a time, read-modify-writes through the single-read-port RAMs.
// Reset and restart: the tape is zeroed by a sweep over all MEM_DEPTH cells
//   (one cell per cycle); no item is taken meanwhile. A restart item
//   answers after its sweep.
// A stalled receiver holds the output register; the next item is accepted
//   and worked, but its result waits until the output register frees up.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core #(
    parameter int MEM_DEPTH   = bfi_pkg::MEM_DEPTH_DEF,
    parameter int PROG_DEPTH  = bfi_pkg::PROG_DEPTH_DEF,
    parameter int INPUT_DEPTH = bfi_pkg::INPUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [12:0] program_counter,
    output logic [15:0] data_pointer,
    output logic [7:0]  cell_value,
    output logic        halted,
    output logic        bracket_error,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int AW   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CW   = (AW + 1 > 17) ? AW + 1 : 17;
    localparam int PA_W = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
    localparam int PC_W = $clog2(PROG_DEPTH + 1);
    localparam int QA_W = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
    localparam int QC_W = $clog2(INPUT_DEPTH + 1);
    localparam int JW   = PC_W + 1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CLEAR   = 7'b0000010,
        S_EXEC    = 7'b0000100,
        S_TAPE    = 7'b0001000,
        S_LOAD_RD = 7'b0010000,
        S_LOAD_WR = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [16:0]       mem_size_reg;
    logic [AW-1:0]     dp_reg, dp_next;
    logic [7:0]        cell_reg, cell_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [PC_W-1:0]   prog_len_reg, prog_len_next;
    logic [PC_W-1:0]   depth_reg, depth_next;
    logic [PA_W-1:0]   pos_reg, pos_next;
    logic [PA_W-1:0]   open_reg, open_next;
    logic [QC_W-1:0]   in_cnt_reg, in_cnt_next;
    logic [QC_W-1:0]   rd_pos_reg, rd_pos_next;
    logic              err_reg, err_next;
    logic              restart_reg, restart_next;
    logic [AW-1:0]     clr_reg, clr_next;

    logic              out_valid_reg;
    logic [12:0]       pc_out_reg;
    logic [15:0]       dp_out_reg;
    logic [7:0]        cell_out_reg;
    logic              halt_out_reg;
    logic              err_out_reg;

    // memory ports
    logic              prog_we;
    logic [PA_W-1:0]   prog_waddr, prog_raddr;
    logic [7:0]        prog_rdata;
    logic              jmp_we;
    logic [PA_W-1:0]   jmp_waddr;
    logic [JW-1:0]     jmp_wdata, jmp_rdata;
    logic              stk_we;
    logic [PA_W-1:0]   stk_waddr, stk_raddr, stk_rdata;
    logic              q_we;
    logic [QA_W-1:0]   q_waddr, q_raddr;
    logic [7:0]        q_rdata;
    logic              tape_we;
    logic [AW-1:0]     tape_waddr, tape_raddr;
    logic [7:0]        tape_wdata, tape_rdata;

    logic              accept;
    logic              is_halted;
    logic              out_free;
    logic [CW-1:0]     size_w;
    logic [CW-1:0]     msz_w;
    logic [AW-1:0]     dp_inc, dp_dec;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign is_halted = err_reg || (pc_reg >= prog_len_reg);
    assign out_free  = !out_valid_reg || out_ready;

    // effective tape size, clamped to 1..MEM_DEPTH
    assign msz_w  = CW'(mem_size_reg);
    assign size_w = (mem_size_reg == 17'd0) ? CW'(1) :
                    ((msz_w > CW'(MEM_DEPTH)) ? CW'(MEM_DEPTH) : msz_w);
    assign dp_inc = ((CW'(dp_reg) + CW'(1)) >= size_w) ? '0 : dp_reg + AW'(1);
    assign dp_dec = (dp_reg == '0) ? AW'(size_w - CW'(1)) : dp_reg - AW'(1);

    always_comb
    begin
        state_next    = state_reg;
        dp_next       = dp_reg;
        cell_next     = cell_reg;
        pc_next       = pc_reg;
        prog_len_next = prog_len_reg;
        depth_next    = depth_reg;
        pos_next      = pos_reg;
        open_next     = open_reg;
        in_cnt_next   = in_cnt_reg;
        rd_pos_next   = rd_pos_reg;
        err_next      = err_reg;
        restart_next  = restart_reg;
        clr_next      = clr_reg;

        prog_we    = 1'b0;
        prog_waddr = prog_len_reg[PA_W-1:0];
        prog_raddr = pc_reg[PA_W-1:0];
        jmp_we     = 1'b0;
        jmp_waddr  = prog_len_reg[PA_W-1:0];
        jmp_wdata  = '0;
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[PA_W-1:0];
        stk_raddr  = PA_W'(depth_reg - PC_W'(1));
        q_we       = 1'b0;
        q_waddr    = in_cnt_reg[QA_W-1:0];
        q_raddr    = rd_pos_reg[QA_W-1:0];
        tape_we    = 1'b0;
        tape_waddr = dp_reg;
        tape_wdata = cell_reg;
        tape_raddr = dp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                    case (mode)
                        bfi_pkg::MODE_LOAD_PROG:
                        begin
                            if (prog_len_reg < PC_W'(PROG_DEPTH))
                            begin
                                prog_we       = 1'b1;
                                jmp_we        = 1'b1;
                                pos_next      = prog_len_reg[PA_W-1:0];
                                prog_len_next = prog_len_reg + PC_W'(1);
                                if (value == bfi_pkg::OP_OPEN)
                                begin
                                    if (depth_reg < PC_W'(PROG_DEPTH))
                                    begin
                                        stk_we     = 1'b1;
                                        depth_next = depth_reg + PC_W'(1);
                                    end
                                end
                                else if (value == bfi_pkg::OP_CLOSE)
                                begin
                                    if (depth_reg == '0)
                                    begin
                                        err_next = 1'b1;
                                    end
                                    else
                                    begin
                                        depth_next = depth_reg - PC_W'(1);
                                        state_next = S_LOAD_RD;
                                    end
                                end
                            end
                        end
                        bfi_pkg::MODE_LOAD_INPUT:
                        begin
                            if (in_cnt_reg < QC_W'(INPUT_DEPTH))
                            begin
                                q_we        = 1'b1;
                                in_cnt_next = in_cnt_reg + QC_W'(1);
                            end
                        end
                        bfi_pkg::MODE_STEP:
                        begin
                            if (!is_halted)
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        default:
                        begin
                            dp_next       = '0;
                            cell_next     = '0;
                            pc_next       = '0;
                            prog_len_next = '0;
                            depth_next    = '0;
                            in_cnt_next   = '0;
                            rd_pos_next   = '0;
                            err_next      = 1'b0;
                            restart_next  = 1'b1;
                            clr_next      = '0;
                            state_next    = S_CLEAR;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                tape_wdata = '0;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_DEPTH - 1))
                begin
                    restart_next = 1'b0;
                    state_next   = restart_reg ? S_DONE : S_IDLE;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                pc_next    = pc_reg + PC_W'(1);
                case (prog_rdata)
                    bfi_pkg::OP_INC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = cell_reg + 8'd1;
                        cell_next  = cell_reg + 8'd1;
                    end
                    bfi_pkg::OP_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = cell_reg - 8'd1;
                        cell_next  = cell_reg - 8'd1;
                    end
                    bfi_pkg::OP_READ:
                    begin
                        tape_we = 1'b1;
                        if (rd_pos_reg < in_cnt_reg)
                        begin
                            tape_wdata  = q_rdata;
                            cell_next   = q_rdata;
                            rd_pos_next = rd_pos_reg + QC_W'(1);
                        end
                        else
                        begin
                            tape_wdata = bfi_pkg::EOF_BYTE;
                            cell_next  = bfi_pkg::EOF_BYTE;
                        end
                    end
                    bfi_pkg::OP_RIGHT:
                    begin
                        dp_next    = dp_inc;
                        tape_raddr = dp_inc;
                        state_next = S_TAPE;
                    end
                    bfi_pkg::OP_LEFT:
                    begin
                        dp_next    = dp_dec;
                        tape_raddr = dp_dec;
                        state_next = S_TAPE;
                    end
                    bfi_pkg::OP_OPEN, bfi_pkg::OP_CLOSE:
                    begin
                        // top bit of a jump entry marks a matched bracket
                        if (!jmp_rdata[JW-1])
                        begin
                            err_next = 1'b1;
                            pc_next  = pc_reg;
                        end
                        else if ((prog_rdata == bfi_pkg::OP_OPEN) == (cell_reg == 8'd0))
                        begin
                            pc_next = jmp_rdata[PC_W-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_TAPE:
            begin
                cell_next  = tape_rdata;
                state_next = S_DONE;
            end
            S_LOAD_RD:
            begin
                open_next = stk_rdata;
                jmp_we    = 1'b1;
                jmp_waddr = pos_reg;
                jmp_wdata = {1'b1, PC_W'(stk_rdata) + PC_W'(1)};
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                jmp_we     = 1'b1;
                jmp_waddr  = open_reg;
                jmp_wdata  = {1'b1, PC_W'(pos_reg) + PC_W'(1)};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mem_size_reg  <= bfi_pkg::MEM_SIZE_RST;
            dp_reg        <= '0;
            cell_reg      <= '0;
            pc_reg        <= '0;
            prog_len_reg  <= '0;
            depth_reg     <= '0;
            in_cnt_reg    <= '0;
            rd_pos_reg    <= '0;
            err_reg       <= 1'b0;
            restart_reg   <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dp_reg       <= dp_next;
            cell_reg     <= cell_next;
            pc_reg       <= pc_next;
            prog_len_reg <= prog_len_next;
            depth_reg    <= depth_next;
            in_cnt_reg   <= in_cnt_next;
            rd_pos_reg   <= rd_pos_next;
            err_reg      <= err_next;
            restart_reg  <= restart_next;
            clr_reg      <= clr_next;
            if (cfg_valid && cfg_ready)
            begin
                mem_size_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        open_reg <= open_next;
        if (state_reg == S_DONE && out_free)
        begin
            pc_out_reg   <= 13'(pc_reg);
            dp_out_reg   <= 16'(dp_reg);
            cell_out_reg <= cell_reg;
            halt_out_reg <= is_halted;
            err_out_reg  <= err_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign program_counter = pc_out_reg;
    assign data_pointer    = dp_out_reg;
    assign cell_value      = cell_out_reg;
    assign halted          = halt_out_reg;
    assign bracket_error   = err_out_reg;

    bfi_ram #(.WIDTH(8), .DEPTH(PROG_DEPTH), .AW(PA_W)) u_prog (
        .clk(clk), .we(prog_we), .waddr(prog_waddr), .wdata(value),
        .raddr(prog_raddr), .rdata(prog_rdata)
    );

    bfi_ram #(.WIDTH(JW), .DEPTH(PROG_DEPTH), .AW(PA_W)) u_jump (
        .clk(clk), .we(jmp_we), .waddr(jmp_waddr), .wdata(jmp_wdata),
        .raddr(prog_raddr), .rdata(jmp_rdata)
    );

    bfi_ram #(.WIDTH(PA_W), .DEPTH(PROG_DEPTH), .AW(PA_W)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(prog_len_reg[PA_W-1:0]),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    bfi_ram #(.WIDTH(8), .DEPTH(INPUT_DEPTH), .AW(QA_W)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(value),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    bfi_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH), .AW(AW)) u_tape (
        .clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
        .raddr(tape_raddr), .rdata(tape_rdata)
    );

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!bracket_error || halted))
        else $error("bracket_error shown without halted");

    a_prog_len: assert property (@(posedge clk) disable iff (!rst_n)
        prog_len_reg <= PC_W'(PROG_DEPTH))
        else $error("program length beyond store");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= prog_len_reg)
        else $error("bracket depth above program length");

    a_queue: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pos_reg <= in_cnt_reg)
        else $error("input read position passed fill count");

endmodule
